>>> hdl/ctone_pkg.sv
// ctone_pkg: constants, register codes and the arctangent table of the tone generator
// used by every module of complex_tone_sample_top
`timescale 1ns / 1ps

package ctone_pkg;

   localparam int TABLE_LEN      = 24;
   localparam int DEF_STAGES     = 16;
   localparam int DEF_PHASE_BITS = 32;

   localparam int XY_W   = 34;
   localparam int Z_W    = 33;
   localparam int AMP_W  = 16;
   localparam int OUT_W  = 16;
   localparam int PROD_W = XY_W + AMP_W;
   localparam int ADDR_W = 4;

   localparam logic [1:0] REG_FREQ_WORD    = 2'd0;
   localparam logic [1:0] REG_PHASE_OFFSET = 2'd1;
   localparam logic [1:0] REG_AMPLITUDE    = 2'd2;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic signed [AMP_W-1:0] AMP_RESET = 16'sd4096;
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [29:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [1:0]             quad;
   } rot_type;

endpackage

>>> hdl/ctone_phase.sv
// ctone_phase: phase accumulation k*freq_word + phase_offset, truncation and quadrant fold
// depends on ctone_pkg
`timescale 1ns / 1ps

module ctone_phase #(
   parameter int PHASE_BITS = ctone_pkg::DEF_PHASE_BITS
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [31:0]            sample_index,
   input  logic [31:0]            freq_word,
   input  logic [31:0]            phase_offset,
   output ctone_pkg::rot_type     rot
);

   localparam logic [31:0] PHASE_MASK = ~(32'hFFFF_FFFF >> PHASE_BITS);
   localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;

   logic [31:0] prod_ff, prod_in;
   logic [31:0] phase, folded, resid;
   logic [1:0]  quad;
   logic signed [ctone_pkg::Z_W-1:0] z_ff, z_in;
   logic [1:0]  quad_ff;

   assign prod_in = sample_index * freq_word;

   always_comb begin
      phase  = (prod_ff + phase_offset) & PHASE_MASK;
      folded = phase + QUARTER_HALF;
      quad   = folded[31:30];
      resid  = phase - {quad, 30'd0};
      z_in   = {{(ctone_pkg::Z_W-32){resid[31]}}, resid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         z_ff    <= z_in;
         quad_ff <= quad;
      end
   end

   assign rot.x    = {{(ctone_pkg::XY_W-30){1'b0}}, ctone_pkg::GAIN_Q30};
   assign rot.y    = '0;
   assign rot.z    = z_ff;
   assign rot.quad = quad_ff;

endmodule

>>> hdl/ctone_cell.sv
// ctone_cell: one rotation-mode cordic micro-rotation with its output register
// depends on ctone_pkg
`timescale 1ns / 1ps

module ctone_cell #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               en,
   input  ctone_pkg::rot_type rot_i,
   output ctone_pkg::rot_type rot_o
);

   localparam logic [29:0] ATAN = ctone_pkg::ATAN_TURNS[IDX];
   localparam logic signed [ctone_pkg::Z_W-1:0] ATAN_Z = {{(ctone_pkg::Z_W-30){1'b0}}, ATAN};

   logic signed [ctone_pkg::XY_W-1:0] dx, dy;
   ctone_pkg::rot_type rot_ff, rot_in;

   always_comb begin
      dx = rot_i.y >>> IDX;
      dy = rot_i.x >>> IDX;
      rot_in.quad = rot_i.quad;
      if (!rot_i.z[ctone_pkg::Z_W-1]) begin
         rot_in.x = rot_i.x - dx;
         rot_in.y = rot_i.y + dy;
         rot_in.z = rot_i.z - ATAN_Z;
      end else begin
         rot_in.x = rot_i.x + dx;
         rot_in.y = rot_i.y - dy;
         rot_in.z = rot_i.z + ATAN_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff <= rot_in;
      end
   end

   assign rot_o = rot_ff;

endmodule

>>> hdl/ctone_out.sv
// ctone_out: quadrant unfold, amplitude multiply, rounding and q4.12 saturation
// depends on ctone_pkg
`timescale 1ns / 1ps

module ctone_out (
   input  logic                                  clock,
   input  logic                                  en,
   input  ctone_pkg::rot_type                    rot,
   input  logic signed [ctone_pkg::AMP_W-1:0]    amplitude,
   output logic signed [ctone_pkg::OUT_W-1:0]    in_phase,
   output logic signed [ctone_pkg::OUT_W-1:0]    quadrature
);

   localparam int SH_W = ctone_pkg::PROD_W - 30;
   localparam logic signed [ctone_pkg::PROD_W-1:0] HALF = 50'sd536870912;
   localparam logic signed [SH_W-1:0] POS_MAX = 20'sd32767;
   localparam logic signed [SH_W-1:0] NEG_MAX = -20'sd32768;

   logic signed [ctone_pkg::XY_W-1:0]   c, s;
   logic signed [ctone_pkg::PROD_W-1:0] pc_ff, pc_in, ps_ff, ps_in;
   logic signed [ctone_pkg::PROD_W-1:0] rc, rs;
   logic signed [SH_W-1:0]              shc, shs;
   logic signed [ctone_pkg::OUT_W-1:0]  i_ff, i_in, q_ff, q_in;

   always_comb begin
      case (rot.quad)
         ctone_pkg::QUAD_0: begin c = rot.x;  s = rot.y;  end
         ctone_pkg::QUAD_1: begin c = -rot.y; s = rot.x;  end
         ctone_pkg::QUAD_2: begin c = -rot.x; s = -rot.y; end
         default:           begin c = rot.y;  s = -rot.x; end
      endcase
      pc_in = ctone_pkg::PROD_W'(amplitude) * ctone_pkg::PROD_W'(c);
      ps_in = ctone_pkg::PROD_W'(amplitude) * ctone_pkg::PROD_W'(s);
   end

   always_comb begin
      rc  = pc_ff + HALF;
      rs  = ps_ff + HALF;
      shc = SH_W'(rc >>> 30);
      shs = SH_W'(rs >>> 30);
      if (shc > POS_MAX)      i_in = 16'sd32767;
      else if (shc < NEG_MAX) i_in = -16'sd32768;
      else                    i_in = shc[ctone_pkg::OUT_W-1:0];
      if (shs > POS_MAX)      q_in = 16'sd32767;
      else if (shs < NEG_MAX) q_in = -16'sd32768;
      else                    q_in = shs[ctone_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff <= pc_in;
         ps_ff <= ps_in;
         i_ff  <= i_in;
         q_ff  <= q_in;
      end
   end

   assign in_phase   = i_ff;
   assign quadrature = q_ff;

endmodule

>>> hdl/complex_tone_sample_top.sv
// Quadrature tone generator: for each sample index word it returns amplitude*cos and
// amplitude*sin of (k*freq_word + phase_offset) as Q4.12. One word is taken every clock
// while the output is not stalled; a result passes through two phase stages, the row of
// cordic cells and two output stages. A stalled output holds the whole pipeline.
// depends on ctone_pkg, ctone_phase, ctone_cell, ctone_out
`timescale 1ns / 1ps

module complex_tone_sample_top #(
   parameter int CORDIC_STAGES = ctone_pkg::DEF_STAGES,
   parameter int PHASE_BITS    = ctone_pkg::DEF_PHASE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [31:0]                 req_sample_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ctone_pkg::OUT_W-1:0] rsp_in_phase,
   output logic signed [ctone_pkg::OUT_W-1:0] rsp_quadrature,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ctone_pkg::ADDR_W-1:0]       paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int N_CELLS = (CORDIC_STAGES < ctone_pkg::TABLE_LEN) ?
                            CORDIC_STAGES : ctone_pkg::TABLE_LEN;
   localparam int LAT = N_CELLS + 4;

   logic [31:0] freq_ff, offset_ff;
   logic signed [ctone_pkg::AMP_W-1:0] amp_ff;
   logic [LAT-1:0] vld_ff;
   logic adv, wr_en;
   logic [1:0] reg_idx;
   ctone_pkg::rot_type rot_w [0:N_CELLS];

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff   <= '0;
         offset_ff <= '0;
         amp_ff    <= ctone_pkg::AMP_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            ctone_pkg::REG_FREQ_WORD:    freq_ff   <= pwdata;
            ctone_pkg::REG_PHASE_OFFSET: offset_ff <= pwdata;
            ctone_pkg::REG_AMPLITUDE:    amp_ff    <= pwdata[ctone_pkg::AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ctone_pkg::REG_FREQ_WORD:    prdata = freq_ff;
         ctone_pkg::REG_PHASE_OFFSET: prdata = offset_ff;
         ctone_pkg::REG_AMPLITUDE:    prdata = {{(32-ctone_pkg::AMP_W){amp_ff[15]}}, amp_ff};
         default:                     prdata = '0;
      endcase
   end

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   ctone_phase #(
      .PHASE_BITS(PHASE_BITS)
   ) u_phase (
      .clock        (clock),
      .en           (adv),
      .sample_index (req_sample_index),
      .freq_word    (freq_ff),
      .phase_offset (offset_ff),
      .rot          (rot_w[0])
   );

   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      ctone_cell #(
         .IDX(i)
      ) u_cell (
         .clock (clock),
         .en    (adv),
         .rot_i (rot_w[i]),
         .rot_o (rot_w[i+1])
      );
   end

   ctone_out u_out (
      .clock      (clock),
      .en         (adv),
      .rot        (rot_w[N_CELLS]),
      .amplitude  (amp_ff),
      .in_phase   (rsp_in_phase),
      .quadrature (rsp_quadrature)
   );

endmodule

>>> hdl/ctone_checker.sv
// ctone_checker: port-level checks of complex_tone_sample_top, bound to the top level
// depends on ctone_pkg and complex_tone_sample_top
`timescale 1ns / 1ps

module ctone_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ctone_pkg::OUT_W-1:0] rsp_in_phase,
   input logic signed [ctone_pkg::OUT_W-1:0] rsp_quadrature,
   input logic                               pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_in_phase) && $stable(rsp_quadrature))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port not ready");

endmodule

bind complex_tone_sample_top ctone_checker u_ctone_checker (.*);

>>> tb/ctone_sample_checker.sv
// ctone_sample_checker: watches the sample, result and register ports of complex_tone_sample_top,
// predicts each I/Q result from its own register copy and compares in order
// depends on ctone_pkg for the field widths and register codes
`timescale 1ns / 1ps

module ctone_sample_checker #(
   parameter int STAGES     = ctone_pkg::DEF_STAGES,
   parameter int PHASE_BITS = ctone_pkg::DEF_PHASE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [31:0]                 req_sample_index,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [ctone_pkg::OUT_W-1:0] rsp_in_phase,
   input  logic signed [ctone_pkg::OUT_W-1:0] rsp_quadrature,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ctone_pkg::ADDR_W-1:0]       paddr,
   input  logic [31:0]                        pwdata,
   input  logic                               pready,
   output int                                 mismatch_count,
   output int                                 outstanding
);

   localparam int      ROT_LEN   = 24;
   localparam longint  ROT_GAIN  = 64'sd652032874;
   localparam int      MAX_SHOWN = 10;

   // rotation angles in turns scaled by 2^32
   localparam longint ATAN_LUT [0:ROT_LEN-1] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465,  10679838,  5340245,   2670163,  1335087,
      667544,    333772,    166886,    83443,    41722,
      20861,     10430,     5215,      2608,     1304,
      652,       326,       163,       81
   };

   typedef struct packed {
      logic [31:0]                        index;
      logic signed [ctone_pkg::OUT_W-1:0] in_phase;
      logic signed [ctone_pkg::OUT_W-1:0] quadrature;
   } tone_word_type;

   logic [31:0]                        freq_word;
   logic [31:0]                        phase_offset;
   logic signed [ctone_pkg::AMP_W-1:0] amplitude;
   tone_word_type                      expected_tones [$];

   function automatic logic signed [ctone_pkg::OUT_W-1:0] scale_q412(longint v);
      longint p;
      p = (longint'(amplitude) * v + (64'sd1 <<< 29)) >>> 30;
      if (p > 32767)
         p = 32767;
      if (p < -32768)
         p = -32768;
      return p[ctone_pkg::OUT_W-1:0];
   endfunction

   function automatic tone_word_type tone_sample(logic [31:0] k);
      logic [31:0]   phase;
      logic [31:0]   biased;
      logic [31:0]   resid;
      logic [31:0]   mask;
      logic [1:0]    quad;
      longint        x, y, z, dx, dy, c, s;
      int            drop;
      tone_word_type res;
      phase = k * freq_word + phase_offset;
      drop = (PHASE_BITS >= 32) ? 0 : ((PHASE_BITS <= 0) ? 32 : 32 - PHASE_BITS);
      mask = (drop >= 32) ? 32'h0 : (32'hFFFF_FFFF << drop);
      phase = phase & mask;
      // fold into the quadrant around the nearest axis
      biased = phase + 32'h2000_0000;
      quad = biased[31:30];
      resid = phase - {quad, 30'b0};
      x = ROT_GAIN;
      y = 0;
      z = longint'($signed(resid));
      for (int i = 0; i < STAGES && i < ROT_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_LUT[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_LUT[i];
         end
      end
      case (quad)
         ctone_pkg::QUAD_0: begin c = x; s = y; end
         ctone_pkg::QUAD_1: begin c = -y; s = x; end
         ctone_pkg::QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      res.index = k;
      res.in_phase = scale_q412(c);
      res.quadrature = scale_q412(s);
      return res;
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding = 0;
      freq_word = '0;
      phase_offset = '0;
      amplitude = ctone_pkg::AMP_RESET;
   end

   always @(posedge clock) begin
      tone_word_type want;
      if (reset) begin
         freq_word = '0;
         phase_offset = '0;
         amplitude = ctone_pkg::AMP_RESET;
         expected_tones.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ctone_pkg::ADDR_W-1:2])
               ctone_pkg::REG_FREQ_WORD:    freq_word = pwdata;
               ctone_pkg::REG_PHASE_OFFSET: phase_offset = pwdata;
               ctone_pkg::REG_AMPLITUDE:    amplitude = pwdata[ctone_pkg::AMP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_tones.push_back(tone_sample(req_sample_index));
         if (rsp_valid && rsp_ready) begin
            if (expected_tones.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("unexpected word: I=%0d Q=%0d", rsp_in_phase, rsp_quadrature);
            end else begin
               want = expected_tones.pop_front();
               if (rsp_in_phase !== want.in_phase || rsp_quadrature !== want.quadrature) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_SHOWN)
                     $display("mismatch k=%0d: expected I=%0d Q=%0d, got I=%0d Q=%0d",
                              $signed(want.index), want.in_phase, want.quadrature,
                              rsp_in_phase, rsp_quadrature);
               end
            end
         end
      end
      outstanding = expected_tones.size();
   end

endmodule

>>> tb/tb_complex_tone_sample_top.sv
// tb_complex_tone_sample_top: drives sample index words and register writes into
// complex_tone_sample_top with random gaps and stalls; ctone_sample_checker does the comparing
// depends on ctone_pkg, complex_tone_sample_top and ctone_sample_checker
`timescale 1ns / 1ps

module tb_complex_tone_sample_top;

   localparam int         STAGES          = ctone_pkg::DEF_STAGES;
   localparam int         PHASE_BITS      = ctone_pkg::DEF_PHASE_BITS;
   localparam int         WATCHDOG_LIMIT  = 5000;
   localparam int         RANDOM_PHASES   = 10;
   localparam int         ITEMS_PER_PHASE = 134;
   localparam logic [1:0] REG_UNUSED      = 2'd3;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [31:0]                 req_sample_index;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [ctone_pkg::OUT_W-1:0] rsp_in_phase;
   logic signed [ctone_pkg::OUT_W-1:0] rsp_quadrature;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [ctone_pkg::ADDR_W-1:0]       paddr;
   logic [31:0]                        pwdata;
   logic [31:0]                        prdata;
   logic                               pready;

   int          mismatch_count;
   int          outstanding;
   int          quiet_cycles;
   bit          no_gaps;
   bit          no_stalls;
   logic [31:0] last_index;

   complex_tone_sample_top #(
      .CORDIC_STAGES(STAGES),
      .PHASE_BITS(PHASE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_in_phase(rsp_in_phase),
      .rsp_quadrature(rsp_quadrature),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   ctone_sample_checker #(
      .STAGES(STAGES),
      .PHASE_BITS(PHASE_BITS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_in_phase(rsp_in_phase),
      .rsp_quadrature(rsp_quadrature),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .pready(pready),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly none or short, a few long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 30);
   endfunction

   function automatic logic [31:0] pick_index();
      int          r;
      logic [31:0] k;
      r = $urandom_range(0, 9);
      if (r < 5)
         k = $urandom;
      else if (r < 7)
         k = $urandom_range(0, 2000) - 1000;
      else if (r == 7)
         case ($urandom_range(0, 3))
            0: k = 32'h7FFF_FFFF;
            1: k = 32'h8000_0000;
            2: k = 32'hFFFF_FFFF;
            default: k = 32'h0;
         endcase
      else if (r == 8)
         k = {3'($urandom_range(0, 7)), 29'b0} + $urandom_range(0, 4) - 2;
      else
         k = last_index + 1;
      return k;
   endfunction

   function automatic logic [31:0] pick_turns();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_amplitude();
      case ($urandom_range(0, 6))
         0: return 32'h0000_8000;
         1: return 32'h0000_7FFF;
         2: return 32'h0;
         3: return 32'h0000_1000;
         default: return $urandom;
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_sample(input logic [31:0] k);
      int gap;
      gap = no_gaps ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_index <= k;
      last_index = k;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic set_tone(input logic [31:0] freq, input logic [31:0] offset,
                           input logic [31:0] gain);
      csr_write(ctone_pkg::REG_FREQ_WORD, freq);
      csr_write(ctone_pkg::REG_PHASE_OFFSET, offset);
      csr_write(ctone_pkg::REG_AMPLITUDE, gain);
   endtask

   // result side back-pressure
   initial begin
      int hold;
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         hold = $urandom_range(1, 20);
         repeat (hold) @(negedge clock);
         stall = no_stalls ? 0 : idle_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_index = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet_cycles = 0;
      no_gaps = 1'b0;
      no_stalls = 1'b0;
      last_index = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: zero phase, unit gain
      send_sample(32'h0);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      drain();

      // phase equals the index: quadrant edges, full positive gain
      set_tone(32'h1, 32'h0, 32'h0000_7FFF);
      send_sample(32'h1FFF_FFFF);
      send_sample(32'h2000_0000);
      send_sample(32'h4000_0000);
      send_sample(32'h6000_0000);
      send_sample(32'h8000_0000);
      send_sample(32'hE000_0000);
      send_sample(32'hDFFF_FFFF);
      drain();

      // wrapping frequency, half-turn offset, most negative gain, write to a hole
      set_tone(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_8000);
      csr_write(REG_UNUSED, 32'h0000_1000);
      send_sample(32'h1);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0);
      send_sample(32'd12345);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         no_gaps = (p % 4 == 1);
         no_stalls = (p % 4 == 1) || (p % 4 == 2);
         set_tone(pick_turns(), pick_turns(), pick_amplitude());
         if ($urandom_range(0, 3) == 0)
            csr_write(REG_UNUSED, $urandom);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(pick_index());
         drain();
      end

      repeat (STAGES + 8) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
